[src/notif_header_option_parser_top_defines.svh]
// assertion macros shared by the notification header parser rtl
// expects i_clk in the scope of every use, and i_rst_n where NHOP_ASSERT is used
`ifndef NOTIF_HEADER_OPTION_PARSER_TOP_DEFINES_SVH
`define NOTIF_HEADER_OPTION_PARSER_TOP_DEFINES_SVH

// checked only while out of reset
`define NHOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define NHOP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/nhop_pkg.sv]
// types and constants for the notification header and option parser
// no dependencies
`default_nettype none

package nhop_pkg;

    typedef enum logic [2:0] {
        CLS_HEADER   = 3'd0,
        CLS_SEG_OPT  = 3'd1,
        CLS_OPT_TYPE = 3'd2,
        CLS_OPT_LEN  = 3'd3,
        CLS_OPT_DATA = 3'd4,
        CLS_PAYLOAD  = 3'd5,
        CLS_BEYOND   = 3'd6
    } t_byte_class;

    localparam logic [15:0] FIXED_HDR_BYTES = 16'd12;
    localparam logic [7:0]  OPT_START_RESET = 8'd12;
    localparam logic [7:0]  OPT_START_MAX   = 8'd255;
    localparam logic [7:0]  SEG_OPT_TYPE    = 8'h01;
    localparam logic [7:0]  MIN_OPT_LEN     = 8'd2;
    localparam logic [15:0] SEG_NUM_HI_OFF  = 16'd2;
    localparam logic [15:0] SEG_NUM_LO_OFF  = 16'd3;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        t_byte_class byte_class;
        logic [7:0]  data_out;
        logic        header_done;
        logic [2:0]  version;
        logic        space_bit;
        logic [3:0]  media_code;
        logic [7:0]  hdr_size;
        logic [15:0] total_len;
        logic [31:0] observation_domain;
        logic [31:0] msg_identifier;
        logic [14:0] segment_number;
        logic        segment_last;
    } t_result;

endpackage

`default_nettype wire

[src/notif_header_option_parser_top.sv]
// Notification segment header and option parser, top level.
// Bytes of a segment enter on the input channel (i_valid, o_stall,
// i_data_byte, i_start_req); i_start_req marks byte 0 of a new segment,
// and after reset the first byte is byte 0 even without it.
// Every accepted byte yields exactly one result transaction on the output
// channel (o_valid, i_stall): the byte class, the byte itself, a flag on
// the last header or option byte, and the header fields decoded so far.
// Path: an accepted byte is registered in the input register or the skid
// entry, decoded, and registered in the output register when it is free.
// Throughput: one byte per cycle while i_stall stays low; decode is a single
// pass between the input register and the output register.
// Stalls: while i_stall holds a result, the input register holds its byte
// and one more byte is caught in the skid entry; o_stall then rises, and
// it comes straight from a flop.
// Reset (i_rst_n low, synchronous) empties both channels and clears all
// decoded fields and the option walk.
// depends on nhop_pkg, nhop_in_skid, nhop_decode
`default_nettype none

module notif_header_option_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_byte_class,
    output logic [7:0]       o_data_out,
    output logic             o_header_done,
    output logic [2:0]       o_version,
    output logic             o_space_bit,
    output logic [3:0]       o_media_code,
    output logic [7:0]       o_hdr_size,
    output logic [15:0]      o_total_len,
    output logic [31:0]      o_observation_domain,
    output logic [31:0]      o_msg_identifier,
    output logic [14:0]      o_segment_number,
    output logic             o_segment_last
);

`include "notif_header_option_parser_top_defines.svh"

    nhop_pkg::t_in_item in_item;
    nhop_pkg::t_in_item stage_item;
    nhop_pkg::t_result  dec_result;
    nhop_pkg::t_result  r_res;
    logic               stage_valid;
    logic               advance;
    logic               r_out_valid;

    assign in_item.data_byte = i_data_byte;
    assign in_item.start_req = i_start_req;

    nhop_in_skid u_in_skid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .o_stall   (o_stall),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    nhop_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_result  (dec_result)
    );

    assign advance = stage_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= dec_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_byte_class         = r_res.byte_class;
    assign o_data_out           = r_res.data_out;
    assign o_header_done        = r_res.header_done;
    assign o_version            = r_res.version;
    assign o_space_bit          = r_res.space_bit;
    assign o_media_code         = r_res.media_code;
    assign o_hdr_size           = r_res.hdr_size;
    assign o_total_len          = r_res.total_len;
    assign o_observation_domain = r_res.observation_domain;
    assign o_msg_identifier     = r_res.msg_identifier;
    assign o_segment_number     = r_res.segment_number;
    assign o_segment_last       = r_res.segment_last;

    `NHOP_ASSERT_ALWAYS(a_reset_empties_output, !i_rst_n |=> !o_valid, "output valid after reset")
    `NHOP_ASSERT(a_done_not_payload, (o_valid && o_header_done) |-> (o_byte_class != nhop_pkg::CLS_PAYLOAD && o_byte_class != nhop_pkg::CLS_BEYOND), "header end flagged on payload byte")

endmodule

`default_nettype wire

[src/nhop_in_skid.sv]
// input register with a one-entry skid so the input stall is a flop
// depends on nhop_pkg
`default_nettype none

module nhop_in_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire nhop_pkg::t_in_item i_item,
    output logic                   o_stall,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output nhop_pkg::t_in_item     o_item
);

`include "notif_header_option_parser_top_defines.svh"

    logic               r_in_valid;
    logic               r_skid_valid;
    nhop_pkg::t_in_item r_in;
    nhop_pkg::t_in_item r_skid;
    logic               accept;
    logic               load_ok;

    assign accept  = i_valid && !r_skid_valid;
    assign load_ok = !r_in_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_ok) begin
            r_in_valid   <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // skid entry is older than anything arriving, so it goes first
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_in <= r_skid_valid ? r_skid : i_item;
        end
        if (!load_ok && accept) begin
            r_skid <= i_item;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_in_valid;
    assign o_item  = r_in;

    `NHOP_ASSERT(a_skid_behind_main, r_skid_valid |-> r_in_valid, "skid filled with main empty")

endmodule

`default_nettype wire

[src/nhop_decode.sv]
// per-byte header and option decode with the segment state registers
// depends on nhop_pkg
`default_nettype none

module nhop_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire nhop_pkg::t_in_item i_item,
    output nhop_pkg::t_result       o_result
);

`include "notif_header_option_parser_top_defines.svh"

    logic [15:0] r_pos;
    logic [7:0]  r_opt_start;
    logic [7:0]  r_opt_type;
    logic [7:0]  r_opt_len;
    logic [2:0]  r_version;
    logic        r_space;
    logic [3:0]  r_media;
    logic [7:0]  r_hdr_len;
    logic [15:0] r_msg_len;
    logic [31:0] r_domain;
    logic [31:0] r_msgid;
    logic [14:0] r_seg_num;
    logic        r_seg_last;

    logic [15:0] n_pos;
    logic [7:0]  n_opt_start;
    logic [7:0]  n_opt_type;
    logic [7:0]  n_opt_len;
    logic [2:0]  n_version;
    logic        n_space;
    logic [3:0]  n_media;
    logic [7:0]  n_hdr_len;
    logic [15:0] n_msg_len;
    logic [31:0] n_domain;
    logic [31:0] n_msgid;
    logic [14:0] n_seg_num;
    logic        n_seg_last;

    logic [15:0]           pos;
    logic [7:0]            b;
    logic [15:0]           off;
    logic [16:0]           off_inc;
    logic [7:0]            typ;
    logic [7:0]            len;
    logic [7:0]            eff;
    logic [8:0]            next_sum;
    logic [7:0]            hdr_end;
    nhop_pkg::t_byte_class cls;

    always_comb begin
        b   = i_item.data_byte;
        pos = i_item.start_req ? 16'd0 : r_pos;

        n_pos       = (pos < nhop_pkg::POS_MAX) ? pos + 16'd1 : nhop_pkg::POS_MAX;
        n_opt_start = r_opt_start;
        n_opt_type  = r_opt_type;
        n_opt_len   = r_opt_len;
        n_version   = r_version;
        n_space     = r_space;
        n_media     = r_media;
        n_hdr_len   = r_hdr_len;
        n_msg_len   = r_msg_len;
        n_domain    = r_domain;
        n_msgid     = r_msgid;
        n_seg_num   = r_seg_num;
        n_seg_last  = r_seg_last;

        // offset inside the current option, wraps like the 16-bit position
        off      = pos - {8'd0, r_opt_start};
        off_inc  = {1'b0, off} + 17'd1;
        typ      = (off == 16'd0) ? b : r_opt_type;
        len      = (off == 16'd0) ? 8'd0 : ((off == 16'd1) ? b : r_opt_len);
        eff      = (len < nhop_pkg::MIN_OPT_LEN) ? nhop_pkg::MIN_OPT_LEN : len;
        next_sum = {1'b0, r_opt_start} + {1'b0, eff};
        cls      = nhop_pkg::CLS_HEADER;

        if (pos == 16'd0) begin
            n_opt_start = nhop_pkg::OPT_START_RESET;
            n_opt_type  = 8'd0;
            n_opt_len   = 8'd0;
            n_seg_num   = 15'd0;
            n_seg_last  = 1'b0;
        end

        if (pos < nhop_pkg::FIXED_HDR_BYTES) begin
            cls = nhop_pkg::CLS_HEADER;
            unique case (pos[3:0])
                4'd0: begin
                    n_version = b[7:5];
                    n_space   = b[4];
                    n_media   = b[3:0];
                end
                4'd1:  n_hdr_len = b;
                4'd2:  n_msg_len[15:8] = b;
                4'd3:  n_msg_len[7:0] = b;
                4'd4:  n_domain[31:24] = b;
                4'd5:  n_domain[23:16] = b;
                4'd6:  n_domain[15:8] = b;
                4'd7:  n_domain[7:0] = b;
                4'd8:  n_msgid[31:24] = b;
                4'd9:  n_msgid[23:16] = b;
                4'd10: n_msgid[15:8] = b;
                4'd11: n_msgid[7:0] = b;
                default: ;
            endcase
        end else if (pos < {8'd0, r_hdr_len}) begin
            n_opt_type = typ;
            n_opt_len  = len;
            if (typ == nhop_pkg::SEG_OPT_TYPE) begin
                cls = nhop_pkg::CLS_SEG_OPT;
                // only bytes inside the option's own length count
                if (off == nhop_pkg::SEG_NUM_HI_OFF && off < {8'd0, eff}) begin
                    n_seg_num[14:7] = b;
                end else if (off == nhop_pkg::SEG_NUM_LO_OFF && off < {8'd0, eff}) begin
                    n_seg_num[6:0] = b[7:1];
                    n_seg_last     = b[0];
                end
            end else if (off == 16'd0) begin
                cls = nhop_pkg::CLS_OPT_TYPE;
            end else if (off == 16'd1) begin
                cls = nhop_pkg::CLS_OPT_LEN;
            end else begin
                cls = nhop_pkg::CLS_OPT_DATA;
            end
            if (off != 16'd0 && off_inc >= {9'd0, eff}) begin
                n_opt_start = (next_sum > {1'b0, nhop_pkg::OPT_START_MAX}) ?
                              nhop_pkg::OPT_START_MAX : next_sum[7:0];
            end
        end else if (pos < r_msg_len) begin
            cls = nhop_pkg::CLS_PAYLOAD;
        end else begin
            cls = nhop_pkg::CLS_BEYOND;
        end

        hdr_end = (n_hdr_len > nhop_pkg::OPT_START_RESET) ? n_hdr_len :
                  nhop_pkg::OPT_START_RESET;

        o_result.byte_class         = cls;
        o_result.data_out           = b;
        o_result.header_done        = (({1'b0, pos} + 17'd1) == {9'd0, hdr_end});
        o_result.version            = n_version;
        o_result.space_bit          = n_space;
        o_result.media_code         = n_media;
        o_result.hdr_size           = n_hdr_len;
        o_result.total_len          = n_msg_len;
        o_result.observation_domain = n_domain;
        o_result.msg_identifier     = n_msgid;
        o_result.segment_number     = n_seg_num;
        o_result.segment_last       = n_seg_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 16'd0;
            r_opt_start <= nhop_pkg::OPT_START_RESET;
            r_opt_type  <= 8'd0;
            r_opt_len   <= 8'd0;
            r_version   <= 3'd0;
            r_space     <= 1'b0;
            r_media     <= 4'd0;
            r_hdr_len   <= 8'd0;
            r_msg_len   <= 16'd0;
            r_domain    <= 32'd0;
            r_msgid     <= 32'd0;
            r_seg_num   <= 15'd0;
            r_seg_last  <= 1'b0;
        end else if (i_advance) begin
            r_pos       <= n_pos;
            r_opt_start <= n_opt_start;
            r_opt_type  <= n_opt_type;
            r_opt_len   <= n_opt_len;
            r_version   <= n_version;
            r_space     <= n_space;
            r_media     <= n_media;
            r_hdr_len   <= n_hdr_len;
            r_msg_len   <= n_msg_len;
            r_domain    <= n_domain;
            r_msgid     <= n_msgid;
            r_seg_num   <= n_seg_num;
            r_seg_last  <= n_seg_last;
        end
    end

    `NHOP_ASSERT(a_opt_start_floor, r_opt_start >= nhop_pkg::OPT_START_RESET, "option walk below fixed header")
    `NHOP_ASSERT(a_pos_saturates, (r_pos == nhop_pkg::POS_MAX && i_advance && !i_item.start_req) |=> r_pos == nhop_pkg::POS_MAX, "byte position wrapped")

endmodule

`default_nettype wire

[tb/nhop_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// scoreboard for the notification header parser bench: predicts every result from the byte stream
// depends on nhop_pkg for the result struct, byte classes and header constants

package nhop_scoreboard_pkg;

    class parse_scoreboard;

        // decoder state, kept as the block keeps it
        bit [15:0] pos;
        bit [7:0]  opt_start;
        bit [7:0]  opt_type;
        bit [7:0]  opt_len;
        bit [2:0]  ver;
        bit        sp;
        bit [3:0]  media;
        bit [7:0]  hdr_len;
        bit [15:0] msg_len;
        bit [31:0] domain;
        bit [31:0] msgid;
        bit [15:0] seg_raw;
        bit        seg_last;

        nhop_pkg::t_result pending_results[$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            pos        = '0;
            opt_start  = nhop_pkg::OPT_START_RESET;
            opt_type   = '0;
            opt_len    = '0;
            ver        = '0;
            sp         = 1'b0;
            media      = '0;
            hdr_len    = '0;
            msg_len    = '0;
            domain     = '0;
            msgid      = '0;
            seg_raw    = '0;
            seg_last   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // one byte inside the type-length option area
        function nhop_pkg::t_byte_class walk_tlv(bit [15:0] p, bit [7:0] b);
            bit [15:0]             off;
            int                    eff;
            int                    nxt;
            nhop_pkg::t_byte_class cls;
            off = p - {8'd0, opt_start};
            if (off == 16'd0) begin
                opt_type = b;
                opt_len  = '0;
            end else if (off == 16'd1) begin
                opt_len = b;
            end
            eff = (opt_len < nhop_pkg::MIN_OPT_LEN) ? int'(nhop_pkg::MIN_OPT_LEN)
                                                    : int'(opt_len);
            if (opt_type == nhop_pkg::SEG_OPT_TYPE) begin
                cls = nhop_pkg::CLS_SEG_OPT;
                // only bytes inside the option's own length touch the segment fields
                if (off == nhop_pkg::SEG_NUM_HI_OFF && int'(off) < eff) begin
                    seg_raw[15:8] = b;
                end else if (off == nhop_pkg::SEG_NUM_LO_OFF && int'(off) < eff) begin
                    seg_raw[7:0] = b;
                    seg_last     = b[0];
                end
            end else if (off == 16'd0) begin
                cls = nhop_pkg::CLS_OPT_TYPE;
            end else if (off == 16'd1) begin
                cls = nhop_pkg::CLS_OPT_LEN;
            end else begin
                cls = nhop_pkg::CLS_OPT_DATA;
            end
            if (off >= 16'd1 && int'(off) + 1 >= eff) begin
                nxt = int'(opt_start) + eff;
                opt_start = (nxt > int'(nhop_pkg::OPT_START_MAX)) ? nhop_pkg::OPT_START_MAX
                                                                 : nxt[7:0];
            end
            return cls;
        endfunction

        function void note_byte(bit [7:0] b, bit start);
            bit [15:0]         p;
            int                hdr_end;
            nhop_pkg::t_result r;
            p = start ? 16'd0 : pos;
            if (p == 16'd0) begin
                opt_start = nhop_pkg::OPT_START_RESET;
                opt_type  = '0;
                opt_len   = '0;
                seg_raw   = '0;
                seg_last  = 1'b0;
            end
            if (p < nhop_pkg::FIXED_HDR_BYTES) begin
                r.byte_class = nhop_pkg::CLS_HEADER;
                case (p)
                    16'd0: {ver, sp, media} = b;
                    16'd1: hdr_len = b;
                    16'd2: msg_len[15:8] = b;
                    16'd3: msg_len[7:0] = b;
                    16'd4, 16'd5, 16'd6, 16'd7: domain[(7 - p) * 8 +: 8] = b;
                    default: msgid[(11 - p) * 8 +: 8] = b;
                endcase
            end else if (p < {8'd0, hdr_len}) begin
                r.byte_class = walk_tlv(p, b);
            end else if (p < msg_len) begin
                r.byte_class = nhop_pkg::CLS_PAYLOAD;
            end else begin
                r.byte_class = nhop_pkg::CLS_BEYOND;
            end
            hdr_end = (hdr_len > nhop_pkg::FIXED_HDR_BYTES) ? int'(hdr_len)
                                                            : int'(nhop_pkg::FIXED_HDR_BYTES);
            r.data_out           = b;
            r.header_done        = (int'(p) + 1 == hdr_end);
            r.version            = ver;
            r.space_bit          = sp;
            r.media_code         = media;
            r.hdr_size           = hdr_len;
            r.total_len          = msg_len;
            r.observation_domain = domain;
            r.msg_identifier     = msgid;
            r.segment_number     = seg_raw[15:1];
            r.segment_last       = seg_last;
            pending_results.push_back(r);
            pos = (p < nhop_pkg::POS_MAX) ? p + 16'd1 : nhop_pkg::POS_MAX;
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
            if (got_val !== exp_val) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: %s expected %0h, got %0h",
                             results_seen, name, exp_val, got_val);
                end
            end
        endfunction

        function void check_result(nhop_pkg::t_result got);
            nhop_pkg::t_result e;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: none outstanding, got data %02h class %0d",
                             results_seen, got.data_out, got.byte_class);
                end
                return;
            end
            e = pending_results.pop_front();
            compare_field("byte_class", e.byte_class, got.byte_class);
            compare_field("data_out", e.data_out, got.data_out);
            compare_field("header_done", e.header_done, got.header_done);
            compare_field("version", e.version, got.version);
            compare_field("space_bit", e.space_bit, got.space_bit);
            compare_field("media_code", e.media_code, got.media_code);
            compare_field("hdr_size", e.hdr_size, got.hdr_size);
            compare_field("total_len", e.total_len, got.total_len);
            compare_field("observation_domain", e.observation_domain,
                          got.observation_domain);
            compare_field("msg_identifier", e.msg_identifier, got.msg_identifier);
            compare_field("segment_number", e.segment_number, got.segment_number);
            compare_field("segment_last", e.segment_last, got.segment_last);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

    endclass

endpackage

[tb/notif_header_option_parser_top_test.sv]
`timescale 1ns / 100ps
// top of the notification header parser bench: clock, reset, byte driver and result monitor
// depends on nhop_pkg, nhop_scoreboard_pkg and notif_header_option_parser_top

module notif_header_option_parser_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 40;
    localparam int DRAIN_CYCLES   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_start_req = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_byte_class;
    logic [7:0]  o_data_out;
    logic        o_header_done;
    logic [2:0]  o_version;
    logic        o_space_bit;
    logic [3:0]  o_media_code;
    logic [7:0]  o_hdr_size;
    logic [15:0] o_total_len;
    logic [31:0] o_observation_domain;
    logic [31:0] o_msg_identifier;
    logic [14:0] o_segment_number;
    logic        o_segment_last;

    nhop_scoreboard_pkg::parse_scoreboard sb = new();

    bit idle_on  = 1'b1;
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int sent_count = 0;

    notif_header_option_parser_top DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_data_byte          (i_data_byte),
        .i_start_req          (i_start_req),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_byte_class         (o_byte_class),
        .o_data_out           (o_data_out),
        .o_header_done        (o_header_done),
        .o_version            (o_version),
        .o_space_bit          (o_space_bit),
        .o_media_code         (o_media_code),
        .o_hdr_size           (o_hdr_size),
        .o_total_len          (o_total_len),
        .o_observation_domain (o_observation_domain),
        .o_msg_identifier     (o_msg_identifier),
        .o_segment_number     (o_segment_number),
        .o_segment_last       (o_segment_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_byte(bit [7:0] b, bit s);
        int gap;
        if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_start_req <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(b, s);
        sent_count++;
    endtask

    task automatic send_bytes(bit [7:0] bytes[$], bit first_start);
        foreach (bytes[k]) send_byte(bytes[k], first_start && k == 0);
    endtask

    task automatic random_segment();
        bit [7:0] seg[$];
        bit [7:0] opts[$];
        bit [7:0] otype;
        bit [7:0] olen;
        int       region;
        int       hl;
        int       hdr_end;
        int       ml;
        quiet = ($urandom_range(0, 3) == 0);
        // junk bytes with scattered start flags
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
            return;
        end
        case ($urandom_range(0, 19))
            0, 1:    region = -1;
            2:       region = $urandom_range(0, 243);
            default: region = $urandom_range(0, 20);
        endcase
        // options may run past the header length and get cut
        while (opts.size() < region) begin
            if ($urandom_range(0, 1) == 1) begin
                otype = nhop_pkg::SEG_OPT_TYPE;
                olen  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 6)) : 8'd4;
            end else begin
                otype = 8'($urandom);
                olen  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1))
                                                    : 8'($urandom_range(2, 10));
            end
            opts.push_back(otype);
            opts.push_back(olen);
            for (int k = 2; k < olen; k++) opts.push_back(8'($urandom));
        end
        hl = (region < 0) ? $urandom_range(0, 11) : 12 + region;
        hdr_end = (hl > 12) ? hl : 12;
        if ($urandom_range(0, 4) == 0) begin
            ml = $urandom_range(0, 65535);
        end else begin
            ml = hdr_end + $urandom_range(0, 10) - $urandom_range(0, 3);
        end
        seg.push_back(8'($urandom));
        seg.push_back(8'(hl));
        seg.push_back(ml[15:8]);
        seg.push_back(ml[7:0]);
        repeat (8) seg.push_back(8'($urandom));
        foreach (opts[k]) seg.push_back(opts[k]);
        repeat ($urandom_range(0, 10)) seg.push_back(8'($urandom));
        // now and then a segment runs on without its start flag
        send_bytes(seg, $urandom_range(0, 11) != 0);
    endtask

    // result side: monitor plus random back-pressure
    initial begin
        nhop_pkg::t_result got;
        int                burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.byte_class         = nhop_pkg::t_byte_class'(o_byte_class);
                got.data_out           = o_data_out;
                got.header_done        = o_header_done;
                got.version            = o_version;
                got.space_bit          = o_space_bit;
                got.media_code         = o_media_code;
                got.hdr_size           = o_hdr_size;
                got.total_len          = o_total_len;
                got.observation_domain = o_observation_domain;
                got.msg_identifier     = o_msg_identifier;
                got.segment_number     = o_segment_number;
                got.segment_last       = o_segment_last;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                burst    = HOLD_CYCLES;
            end
            if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                burst = $urandom_range(0, 4);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ends the run if no transaction moves for too long
    initial begin
        int still;
        still = 0;
        while (still < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                still = 0;
            end else begin
                still++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int seg_idx;
        int mark;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no start flag after reset; full, short and cut options, payload then beyond
        send_bytes('{8'hFF, 8'd22, 8'h00, 8'd24, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'h04, 8'hFF, 8'hFF,
                     8'h80, 8'h01,
                     8'h01, 8'h00,
                     8'h05, 8'h09,
                     8'hAA, 8'h55, 8'h33, 8'hCC}, 1'b0);
        // header length below the fixed header
        send_bytes('{8'h00, 8'd5, 8'h00, 8'd13, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h80, 8'h00, 8'h00, 8'h01, 8'h5A, 8'hA5}, 1'b1);

        seg_idx = 0;
        while (sent_count < 540) begin
            // long receiver hold-off so the input side backs up
            if (seg_idx % 6 == 0) hold_req = 1'b1;
            random_segment();
            seg_idx++;
        end

        idle_on = 1'b0;
        quiet   = 1'b0;
        mark    = sent_count;
        while (sent_count < mark + 60) random_segment();
        i_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/nhop_pkg.sv
src/nhop_in_skid.sv
src/nhop_decode.sv
src/notif_header_option_parser_top.sv
tb/nhop_scoreboard_pkg.sv
tb/notif_header_option_parser_top_test.sv
